FILE: rtl/fhs_pkg.sv
// Shared types and constants for the framed heartbeat supervisor.
// Depends on nothing; every other file imports it.
package fhs_pkg;

	localparam int BYTE_W  = 8;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 24;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

	// register reset values
	localparam logic [BYTE_W-1:0] SYNC_RST   = 8'hAA;
	localparam logic [BYTE_W-1:0] MISS_RST   = 8'd3;
	localparam logic [BYTE_W-1:0] PERIOD_RST = 8'd5;
	localparam logic [BYTE_W-1:0] MISS_MAX   = 8'hFF;

	// driver states
	localparam logic [BYTE_W-1:0] DRV_OFF   = 8'd0;
	localparam logic [BYTE_W-1:0] DRV_BLINK = 8'd1;
	localparam logic [BYTE_W-1:0] DRV_ON    = 8'd2;

	localparam logic [1:0] LAST_DATA_IDX = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_value;
		logic [BYTE_W-1:0] miss_limit;
		logic [BYTE_W-1:0] beat_period;
	} cfg_t;

	typedef struct packed {
		logic              frame_ok;
		logic              frame_bad;
		logic [BYTE_W-1:0] driver_level;
	} frame_status_t;

	typedef struct packed {
		logic              frame_ok;
		logic              frame_bad;
		logic [BYTE_W-1:0] driver_level;
		logic              peer_ok;
		logic              fault_report;
		logic              beat_due;
		logic [BYTE_W-1:0] beat_count;
		logic              led_on;
	} result_t;

endpackage

FILE: rtl/fhs_frame_parser.sv
// Frame parser: sync hunt, frame byte store, checksum, latched driver and sequence.
// Depends on fhs_pkg.
module fhs_frame_parser
	import fhs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [CMD_W-1:0]  command,
	input  logic [BYTE_W-1:0] data_byte,
	input  cfg_t              cfg,
	output frame_status_t     status,
	output logic [BYTE_W-1:0] seq_now
);

	logic              collecting_q;
	logic [1:0]        idx_q;
	logic [BYTE_W-1:0] frame_q [3];
	logic [BYTE_W-1:0] driver_q;
	logic [BYTE_W-1:0] seq_q;
	logic [BYTE_W-1:0] sum;
	logic              is_byte;
	logic              at_check;
	logic              good;

	assign is_byte  = acc && (command == CMD_BYTE);
	assign at_check = collecting_q && (idx_q == LAST_DATA_IDX);
	assign sum      = cfg.sync_value + frame_q[0] + frame_q[1] + frame_q[2];
	assign good     = (sum == data_byte);

	always_comb begin
		status.frame_ok     = is_byte && at_check && good;
		status.frame_bad    = is_byte && at_check && !good;
		status.driver_level = status.frame_ok ? frame_q[0] : driver_q;
	end

	assign seq_now = seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			idx_q        <= 2'd0;
			driver_q     <= '0;
			seq_q        <= '0;
		end else if (is_byte) begin
			if (!collecting_q) begin
				if (data_byte == cfg.sync_value) begin
					collecting_q <= 1'b1;
					idx_q        <= 2'd0;
				end
			end else if (!at_check) begin
				idx_q <= idx_q + 2'd1;
			end else begin
				if (good) begin
					driver_q <= frame_q[0];
					seq_q    <= frame_q[2];
				end
				collecting_q <= 1'b0;
				idx_q        <= 2'd0;
			end
		end
	end

	// frame store: payload only, written before read within a frame
	always_ff @(posedge clk) begin
		if (is_byte && collecting_q && !at_check) begin
			frame_q[idx_q] <= data_byte;
		end
	end

endmodule

FILE: rtl/fhs_supervisor.sv
// Peer watchdog, fault report, LED drive and own heartbeat counter.
// Depends on fhs_pkg.
module fhs_supervisor
	import fhs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [CMD_W-1:0]  command,
	input  cfg_t              cfg,
	input  logic [BYTE_W-1:0] seq_now,
	input  logic [BYTE_W-1:0] driver_level,
	output logic              peer_ok,
	output logic              fault_report,
	output logic              beat_due,
	output logic [BYTE_W-1:0] beat_count,
	output logic              led_on
);

	logic [BYTE_W-1:0] seq_seen_q, miss_q, ticks_q, beats_q;
	logic              alive_q, armed_q, sent_q, led_q;

	logic [BYTE_W-1:0] seq_seen_n, miss_n, ticks_n, beats_n, ticks_inc;
	logic              alive_n, armed_n, sent_n, led_n, blink;
	logic              is_sup, is_loop, same;

	assign is_sup    = acc && (command == CMD_SUP);
	assign is_loop   = acc && (command == CMD_LOOP);
	assign same      = (seq_now == seq_seen_q);
	assign ticks_inc = ticks_q + 8'd1;

	always_comb begin
		seq_seen_n   = seq_seen_q;
		miss_n       = miss_q;
		alive_n      = alive_q;
		armed_n      = armed_q;
		sent_n       = sent_q;
		led_n        = led_q;
		ticks_n      = ticks_q;
		beats_n      = beats_q;
		fault_report = 1'b0;
		beat_due     = 1'b0;
		blink        = 1'b0;
		if (is_sup) begin
			if (same) begin
				if (miss_q != MISS_MAX) miss_n = miss_q + 8'd1;
			end else begin
				miss_n     = '0;
				alive_n    = 1'b1;
				seq_seen_n = seq_now;
			end
			if (miss_n >= cfg.miss_limit) alive_n = 1'b0;
			armed_n = 1'b1;
		end
		if (is_loop) begin
			fault_report = !alive_q && !sent_q;
			sent_n       = !alive_q;
			if (!alive_q) begin
				blink = 1'b1;
			end else begin
				case (driver_level)
					DRV_OFF:   led_n = 1'b0;
					DRV_BLINK: blink = 1'b1;
					DRV_ON:    led_n = 1'b1;
					default:   led_n = led_q;
				endcase
			end
			if (blink && armed_q) begin
				armed_n = 1'b0;
				led_n   = !led_q;
			end
			ticks_n = ticks_inc;
			if (ticks_inc >= cfg.beat_period) begin
				ticks_n  = '0;
				beats_n  = beats_q + 8'd1;
				beat_due = 1'b1;
			end
		end
	end

	assign peer_ok    = alive_n;
	assign beat_count = beats_n;
	assign led_on     = led_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_seen_q <= '0;
			miss_q     <= '0;
			alive_q    <= 1'b1;
			armed_q    <= 1'b0;
			sent_q     <= 1'b0;
			led_q      <= 1'b0;
			ticks_q    <= '0;
			beats_q    <= '0;
		end else begin
			seq_seen_q <= seq_seen_n;
			miss_q     <= miss_n;
			alive_q    <= alive_n;
			armed_q    <= armed_n;
			sent_q     <= sent_n;
			led_q      <= led_n;
			ticks_q    <= ticks_n;
			beats_q    <= beats_n;
		end
	end

endmodule

FILE: rtl/fhs_out_buffer.sv
// Result register with a skid entry; the input stalls only while the skid entry is full.
// Depends on fhs_pkg.
module fhs_out_buffer
	import fhs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    take;

	assign take      = out_v_q && out_ready;
	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (in_valid) begin
			if (out_v_q && !take) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (in_valid) begin
			if (out_v_q && !take) skid_q <= in_data;
			else out_q <= in_data;
		end
	end

endmodule

FILE: rtl/framed_heartbeat_supervisor.sv
// Top level of the framed heartbeat supervisor: config registers, parser,
// supervisor and result buffer. Depends on fhs_pkg and the fhs_* modules.
//
// Usage:
//   Input stream (s_*): s_tuser carries the command (byte, supervision tick,
//   loop tick), s_tdata the received byte. Every transfer yields exactly one
//   status result on the output stream (m_*).
//   A result is registered in the output register, or in the skid entry
//   while that holds an untaken one. Throughput: one transfer per cycle
//   while s_tready is high; frame and watchdog registers update per transfer.
//   Stall: a result waiting on m_tready is held in the output register and
//   one more is kept in a skid entry; s_tready drops only while the skid
//   entry is full.
//   Configuration: cfg_wen writes cfg_wdata to register cfg_index at the
//   clock edge (0 sync byte, 1 miss limit, 2 beat period); other indexes are
//   ignored. Write only while the block is idle.
//   Reset (arst_n low): hunt for sync, peer alive, LED off, counters clear,
//   registers back to sync 0xAA, miss limit 3, beat period 5; no result held.
module framed_heartbeat_supervisor
	import fhs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] frame_ok, [1] frame_bad, [9:2] driver_level, [10] peer_ok,
	// [11] fault_report, [12] beat_due, [20:13] beat_count, [21] led_on,
	// [23:22] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_wdata
);

	cfg_t              cfg_q;
	logic              acc;
	frame_status_t     fstat;
	logic [BYTE_W-1:0] seq_now;
	result_t           res, res_out;

	// register file: hold each value until its index is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value  <= SYNC_RST;
			cfg_q.miss_limit  <= MISS_RST;
			cfg_q.beat_period <= PERIOD_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SYNC:   cfg_q.sync_value  <= cfg_wdata;
				CFG_MISS:   cfg_q.miss_limit  <= cfg_wdata;
				CFG_PERIOD: cfg_q.beat_period <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// advance the state only on an input transfer
	assign acc = s_tvalid && s_tready;

	fhs_frame_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.command   (s_tuser),
		.data_byte (s_tdata),
		.cfg       (cfg_q),
		.status    (fstat),
		.seq_now   (seq_now)
	);

	// the supervisor sees the driver state after this step; only a byte
	// changes it, and the supervisor acts only on ticks, so both agree
	fhs_supervisor u_super (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.command      (s_tuser),
		.cfg          (cfg_q),
		.seq_now      (seq_now),
		.driver_level (fstat.driver_level),
		.peer_ok      (res.peer_ok),
		.fault_report (res.fault_report),
		.beat_due     (res.beat_due),
		.beat_count   (res.beat_count),
		.led_on       (res.led_on)
	);

	assign res.frame_ok     = fstat.frame_ok;
	assign res.frame_bad    = fstat.frame_bad;
	assign res.driver_level = fstat.driver_level;

	fhs_out_buffer u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	// pack the result, first field in the lowest bit
	assign m_tdata = {2'b00, res_out.led_on, res_out.beat_count, res_out.beat_due,
		res_out.fault_report, res_out.peer_ok, res_out.driver_level,
		res_out.frame_bad, res_out.frame_ok};

endmodule

FILE: test/framed_heartbeat_supervisor_test.sv
// Self-checking bench for framed_heartbeat_supervisor: frame parsing, peer watchdog,
// LED and own heartbeat, under bursty input and a stalling receiver.
// Depends on fhs_pkg and the RTL top; everything else is built in here.
module framed_heartbeat_supervisor_test;
	import fhs_pkg::*;

	// command code the block leaves unused; it must still answer with status
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	// register index that decodes to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	// receiver stall patterns
	localparam int RDY_FULL     = 0;
	localparam int RDY_LIGHT    = 1;
	localparam int RDY_HEAVY    = 2;
	localparam int RDY_PERIODIC = 3;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data;
	} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;    // [7:0] data_byte
	logic [CMD_W-1:0]      s_tuser = '0;    // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [0] frame_ok, [1] frame_bad, [9:2] driver_level, [10] peer_ok,
	// [11] fault_report, [12] beat_due, [20:13] beat_count, [21] led_on
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [BYTE_W-1:0]     cfg_wdata = '0;

	framed_heartbeat_supervisor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: configuration and state, advanced once per
	// accepted input transfer.
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] cfg_sync;
	logic [BYTE_W-1:0] cfg_miss;
	logic [BYTE_W-1:0] cfg_period;

	logic              in_frame;
	logic [2:0]        fill_idx;
	logic [BYTE_W-1:0] frame_store [0:2];
	logic [BYTE_W-1:0] drv_state;
	logic [BYTE_W-1:0] seq_latched;
	logic [BYTE_W-1:0] seq_last;
	logic [BYTE_W-1:0] miss_run;
	logic              peer_alive;
	logic              blink_pending;
	logic              fault_flagged;
	logic              led;
	logic [BYTE_W-1:0] tick_count;
	logic [BYTE_W-1:0] beat_ctr;

	stim_t   pending_items [$];
	result_t expected_status [$];

	int items_queued = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int good_frames = 0;
	int bad_frames = 0;
	int fault_reports = 0;
	int heartbeats = 0;
	int settings_run = 0;
	int cycle_count = 0;

	// consume one armed blink step, if any
	function automatic void blink_once();
		if (blink_pending) begin
			blink_pending = 1'b0;
			led = ~led;
		end
	endfunction

	// advance the shadow by one transfer and return the status it answers with
	function automatic result_t next_status(input logic [CMD_W-1:0] cmd,
	                                        input logic [BYTE_W-1:0] b);
		result_t r;
		logic [BYTE_W-1:0] sum;
		r = '0;
		case (cmd)
		CMD_BYTE: begin
			if (!in_frame) begin
				// hunting: only the sync byte opens a frame
				if (b == cfg_sync) begin
					in_frame = 1'b1;
					fill_idx = '0;
				end
			end else if (fill_idx < 3'd3) begin
				// inside a frame every byte is data, sync value included
				frame_store[fill_idx[1:0]] = b;
				fill_idx = fill_idx + 3'd1;
			end else begin
				sum = cfg_sync + frame_store[0] + frame_store[1] + frame_store[2];
				if (sum == b) begin
					drv_state = frame_store[0];
					seq_latched = frame_store[2];
					r.frame_ok = 1'b1;
				end else begin
					r.frame_bad = 1'b1;
				end
				in_frame = 1'b0;
				fill_idx = '0;
			end
		end
		CMD_SUP: begin
			if (seq_latched == seq_last) begin
				if (miss_run < MISS_MAX)
					miss_run = miss_run + 8'd1;
			end else begin
				miss_run = '0;
				peer_alive = 1'b1;
				seq_last = seq_latched;
			end
			if (miss_run >= cfg_miss)
				peer_alive = 1'b0;
			blink_pending = 1'b1;
		end
		CMD_LOOP: begin
			// fault goes out once per loss of the peer
			if (!peer_alive && !fault_flagged) begin
				r.fault_report = 1'b1;
				fault_flagged = 1'b1;
			end else if (peer_alive) begin
				fault_flagged = 1'b0;
			end
			// unknown driver states leave the LED and the armed blink alone
			if (!peer_alive)
				blink_once();
			else if (drv_state == DRV_OFF)
				led = 1'b0;
			else if (drv_state == DRV_BLINK)
				blink_once();
			else if (drv_state == DRV_ON)
				led = 1'b1;
			tick_count = tick_count + 8'd1;
			if (tick_count >= cfg_period) begin
				tick_count = '0;
				beat_ctr = beat_ctr + 8'd1;
				r.beat_due = 1'b1;
			end
		end
		default: ;
		endcase
		r.driver_level = drv_state;
		r.peer_ok = peer_alive;
		r.beat_count = beat_ctr;
		r.led_on = led;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	logic [BYTE_W-1:0] last_seq_sent = '0;

	task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
		stim_t s;
		s.cmd = cmd;
		s.data = data;
		pending_items.push_back(s);
		items_queued++;
	endtask

	// queue a whole frame; checksum follows the sync value in force now
	task automatic push_frame(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
	                          input logic [BYTE_W-1:0] b2, input bit corrupt);
		logic [BYTE_W-1:0] sum;
		sum = cfg_sync + b0 + b1 + b2;
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		push_item(CMD_BYTE, cfg_sync);
		push_item(CMD_BYTE, b0);
		push_item(CMD_BYTE, b1);
		push_item(CMD_BYTE, b2);
		push_item(CMD_BYTE, sum);
		last_seq_sent = b2;
	endtask

	// mostly well-formed frames mixed with ticks; some noise and cut frames
	task automatic gen_random(input int count);
		int target;
		int pick;
		int cut;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		target = items_queued + count;
		while (items_queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				b0 = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2)) : 8'($urandom);
				b1 = ($urandom_range(0, 9) == 0) ? cfg_sync : 8'($urandom);
				// repeat the sequence half the time so the watchdog can expire
				b2 = ($urandom_range(0, 1) == 0) ? last_seq_sent : 8'($urandom);
				push_frame(b0, b1, b2, $urandom_range(0, 99) < 15);
			end else if (pick < 55) begin
				push_item(CMD_BYTE, 8'($urandom));
			end else if (pick < 60) begin
				// frame cut short; later bytes get swallowed as its data
				cut = $urandom_range(1, 3);
				push_item(CMD_BYTE, cfg_sync);
				repeat (cut)
					push_item(CMD_BYTE, 8'($urandom));
			end else if (pick < 80) begin
				push_item(CMD_SUP, 8'($urandom));
			end else if (pick < 97) begin
				push_item(CMD_LOOP, 8'($urandom));
			end else begin
				push_item(CMD_NONE, 8'($urandom));
			end
		end
	endtask

	// register write while idle; the shadow follows at once
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		CFG_SYNC:   cfg_sync = val;
		CFG_MISS:   cfg_miss = val;
		CFG_PERIOD: cfg_period = val;
		default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// hold until every queued item went through and every result came back
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		settings_run++;
	endtask

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("mismatch at result %0d: %s got %0d, expected %0d",
		         results_checked, what, got_v, want_v);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	stim_t cur_item;
	int    burst_left = 0;
	int    gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			// predict on the transfer that completes at this edge
			if (s_tvalid && s_tready) begin
				expected_status.push_back(next_status(cur_item.cmd, cur_item.data));
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_item.data;
					s_tuser <= cur_item.cmd;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						// now and then a long burst, and now and then no gap at all
						burst_left = ($urandom_range(0, 4) == 0) ?
						             $urandom_range(60, 120) : $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall pattern on m_tready, check every result transfer
	// ------------------------------------------------------------------
	result_t got;
	result_t want;
	int      rdy_mode = RDY_FULL;
	int      rdy_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.frame_ok = m_tdata[0];
				got.frame_bad = m_tdata[1];
				got.driver_level = m_tdata[9:2];
				got.peer_ok = m_tdata[10];
				got.fault_report = m_tdata[11];
				got.beat_due = m_tdata[12];
				got.beat_count = m_tdata[20:13];
				got.led_on = m_tdata[21];
				if (expected_status.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = expected_status.pop_front();
					if (got.frame_ok != want.frame_ok)
						report_mismatch("frame_ok", int'(got.frame_ok),
						                int'(want.frame_ok));
					if (got.frame_bad != want.frame_bad)
						report_mismatch("frame_bad", int'(got.frame_bad),
						                int'(want.frame_bad));
					if (got.driver_level != want.driver_level)
						report_mismatch("driver_level", int'(got.driver_level),
						                int'(want.driver_level));
					if (got.peer_ok != want.peer_ok)
						report_mismatch("peer_ok", int'(got.peer_ok),
						                int'(want.peer_ok));
					if (got.fault_report != want.fault_report)
						report_mismatch("fault_report", int'(got.fault_report),
						                int'(want.fault_report));
					if (got.beat_due != want.beat_due)
						report_mismatch("beat_due", int'(got.beat_due),
						                int'(want.beat_due));
					if (got.beat_count != want.beat_count)
						report_mismatch("beat_count", int'(got.beat_count),
						                int'(want.beat_count));
					if (got.led_on != want.led_on)
						report_mismatch("led_on", int'(got.led_on),
						                int'(want.led_on));
					good_frames += int'(want.frame_ok);
					bad_frames += int'(want.frame_bad);
					fault_reports += int'(want.fault_report);
					heartbeats += int'(want.beat_due);
				end
				results_checked++;
			end
			// switch to a random stall pattern when the current run is used up
			if (rdy_left == 0) begin
				rdy_mode = $urandom_range(RDY_FULL, RDY_PERIODIC);
				rdy_left = $urandom_range(8, 64);
			end else begin
				rdy_left--;
			end
			case (rdy_mode)
			RDY_FULL:  m_tready <= 1'b1;
			RDY_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
			RDY_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= ((rdy_left % 5) < 2);
			endcase
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, expected_status.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: reset, directed cases, then random phases under several
	// register settings, writing registers only while idle.
	// ------------------------------------------------------------------
	initial begin
		cfg_sync = SYNC_RST;
		cfg_miss = MISS_RST;
		cfg_period = PERIOD_RST;
		in_frame = 1'b0;
		fill_idx = '0;
		frame_store[0] = '0;
		frame_store[1] = '0;
		frame_store[2] = '0;
		drv_state = '0;
		seq_latched = '0;
		seq_last = '0;
		miss_run = '0;
		peer_alive = 1'b1;
		blink_pending = 1'b0;
		fault_flagged = 1'b0;
		led = 1'b0;
		tick_count = '0;
		beat_ctr = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings
		push_item(CMD_NONE, 8'hFF);                 // unused command
		push_item(CMD_BYTE, 8'h00);                 // noise while hunting
		push_frame(DRV_ON, SYNC_RST, 8'h01, 1'b0);  // sync value inside the frame
		push_item(CMD_LOOP, 8'h00);                 // LED on
		push_item(CMD_SUP, 8'h00);                  // new sequence, peer alive
		push_frame(DRV_OFF, 8'h55, 8'hFF, 1'b1);    // bad checksum, dropped
		repeat (3)
			push_item(CMD_SUP, 8'h00);              // peer runs out of misses
		push_item(CMD_LOOP, 8'h00);                 // fault report, blink
		push_item(CMD_LOOP, 8'h00);                 // no second report
		push_frame(8'hFF, 8'h00, 8'h80, 1'b0);      // unknown driver state
		push_item(CMD_SUP, 8'h00);                  // peer back
		push_item(CMD_LOOP, 8'h00);                 // LED and armed blink kept
		push_item(CMD_LOOP, 8'h00);                 // fifth tick: own heartbeat
		gen_random(150);
		drain();

		// low settings: sync byte zero, miss limit and beat period one
		write_reg(CFG_SYNC, 8'h00);
		write_reg(CFG_MISS, 8'd1);
		write_reg(CFG_PERIOD, 8'd1);
		gen_random(150);
		drain();

		// highest settings; a long run of unchanged ticks saturates the miss count
		write_reg(CFG_SYNC, 8'hFF);
		write_reg(CFG_MISS, 8'hFF);
		write_reg(CFG_PERIOD, 8'hFF);
		write_reg(CFG_NONE, 8'h12);
		repeat (280)
			push_item(CMD_SUP, 8'($urandom));
		gen_random(100);
		drain();

		// lowered period with ticks already counted, zero miss limit
		write_reg(CFG_SYNC, 8'h5A);
		write_reg(CFG_MISS, 8'd0);
		write_reg(CFG_PERIOD, 8'd7);
		gen_random(120);
		drain();

		// zero period: heartbeat on every loop tick
		write_reg(CFG_PERIOD, 8'd0);
		gen_random(80);
		drain();

		repeat (2) begin
			write_reg(CFG_SYNC, 8'($urandom));
			write_reg(CFG_MISS, 8'($urandom_range(1, 8)));
			write_reg(CFG_PERIOD, 8'($urandom_range(1, 8)));
			gen_random(100);
			drain();
		end

		$display("ran %0d transfers over %0d register settings, %0d results checked",
		         items_sent, settings_run, results_checked);
		$display("saw %0d good and %0d bad frames, %0d fault reports, %0d heartbeats",
		         good_frames, bad_frames, fault_reports, heartbeats);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/fhs_pkg.sv
rtl/fhs_frame_parser.sv
rtl/fhs_supervisor.sv
rtl/fhs_out_buffer.sv
rtl/framed_heartbeat_supervisor.sv
test/framed_heartbeat_supervisor_test.sv
